// ===== rtl/core/fws_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and sector table of the flash write sequencer
package fws_pkg;

   // command codes of a request beat
   localparam logic [1:0] CMD_SUBMIT = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_INIT   = 2'd2;

   // flash operation codes
   localparam logic [1:0] OP_NONE    = 2'd0;
   localparam logic [1:0] OP_ERASE   = 2'd1;
   localparam logic [1:0] OP_PROGRAM = 2'd2;

   // job outcome codes
   localparam logic [1:0] OUTCOME_NONE = 2'd0;
   localparam logic [1:0] OUTCOME_OK   = 2'd1;
   localparam logic [1:0] OUTCOME_FAIL = 2'd2;

   localparam int ADDR_W       = 21;
   localparam int PLANE_W      = 22;
   localparam int SECTOR_COUNT = 9;

   localparam logic [PLANE_W-1:0] BOOT_BYTES = 22'h010000;

   // absolute plane boundaries, sector i spans [bound i, bound i+1)
   localparam logic [PLANE_W-1:0] SECTOR_BOUNDS [0:SECTOR_COUNT] = '{
      22'h010000, 22'h020000, 22'h040000, 22'h080000, 22'h0C0000,
      22'h100000, 22'h140000, 22'h180000, 22'h1C0000, 22'h200000
   };

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_START      = 3'd1,
      PH_ERASE_WAIT = 3'd2,
      PH_PAGE       = 3'd3,
      PH_PAGE_WAIT  = 3'd4,
      PH_OK         = 3'd5,
      PH_ERROR      = 3'd6,
      PH_FINISH     = 3'd7
   } phase_type;

   // sector lookup result, offsets relative to the end of the boot area
   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] first;
      logic [ADDR_W-1:0] last;
   } sector_type;

endpackage

// ===== rtl/core/fws_sector_map.sv =====
`timescale 1ns / 1ps
// sector lookup: maps a write offset to the enclosing erase sector
module fws_sector_map
   import fws_pkg::*;
(
   input  logic [ADDR_W-1:0] offset,
   output sector_type        sector
);

   logic [PLANE_W-1:0] plane_addr;

   assign plane_addr = {1'b0, offset} + BOOT_BYTES;

   // nine independent range compares, at most one hits
   always_comb begin
      sector = '0;
      for (int i = 0; i < SECTOR_COUNT; i++) begin
         if (plane_addr >= SECTOR_BOUNDS[i] && plane_addr < SECTOR_BOUNDS[i+1]) begin
            sector.hit   = 1'b1;
            sector.first = ADDR_W'(SECTOR_BOUNDS[i] - BOOT_BYTES);
            sector.last  = ADDR_W'(SECTOR_BOUNDS[i+1] - BOOT_BYTES - 22'd1);
         end
      end
   end

endmodule

// ===== rtl/core/flash_write_sequencer.sv =====
`timescale 1ns / 1ps
// top level of the flash write sequencer
//
// Each request beat carries a command: submit a job (offset above the boot
// area, byte length, buffer base), a flash status tick, or init. Every request
// beat gives exactly one response beat that reports the operation issued on
// that step (erase sector or program page, with its addresses), whether a
// submit was taken, the job outcome, the wrapping ok and fail counters and
// whether the sequencer is idle afterwards. The sequencer moves at most one
// phase per tick: sector check and erase, erase wait, program page, page wait,
// outcome, finish. Submits while busy and zero length submits are dropped
// with job_taken low; init clears the counters and the erased sector window
// and aborts any job without counting it. Throughput is one beat per clock
// while the response side is not stalled; an accepted request beat sits in
// the request register, and the response register loads it at the next edge,
// unless a stalled response still holds it.
// All per-beat work (sector compare, address and length update, counter
// bump) is one combinational pass between those two registers, and the
// sequencer state is written in the same edge that loads the response, so
// the next beat sees it right away.
module flash_write_sequencer
   import fws_pkg::*;
#(
   parameter int PAGE_BYTES  = 256,
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [20:0] req_job_address,
   input  logic [15:0] req_job_length,
   input  logic [31:0] req_buffer_base,
   input  logic        req_flash_busy,
   input  logic        req_flash_error,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_op_kind,
   output logic [20:0] rsp_op_address,
   output logic [31:0] rsp_data_address,
   output logic        rsp_job_taken,
   output logic [1:0]  rsp_job_outcome,
   output logic [15:0] rsp_ok_total,
   output logic [15:0] rsp_fail_total,
   output logic        rsp_idle
);

   localparam logic [ADDR_W-1:0] PageStep   = ADDR_W'(PAGE_BYTES);
   localparam logic [31:0]       PagePtr    = 32'(PAGE_BYTES);
   localparam logic [15:0]       PageLength = 16'(PAGE_BYTES);

   // request register
   logic              in_valid_ff;
   logic [1:0]        cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [15:0]       len_ff;
   logic [31:0]       base_ff;
   logic              busy_ff;
   logic              err_ff;

   // sequencer state
   phase_type              phase_ff, phase_in;
   logic [ADDR_W-1:0]      win_start_ff, win_start_in;
   logic [ADDR_W-1:0]      win_end_ff, win_end_in;
   logic [ADDR_W-1:0]      offset_ff, offset_in;
   logic [15:0]            left_ff, left_in;
   logic [31:0]            pointer_ff, pointer_in;
   logic [COUNT_WIDTH-1:0] ok_cnt_ff, ok_cnt_in;
   logic [COUNT_WIDTH-1:0] fail_cnt_ff, fail_cnt_in;

   // response register
   logic              rsp_valid_ff;
   logic [1:0]        op_kind_ff, op_kind_in;
   logic [ADDR_W-1:0] op_addr_ff, op_addr_in;
   logic [31:0]       data_addr_ff, data_addr_in;
   logic              taken_ff, taken_in;
   logic [1:0]        outcome_ff, outcome_in;
   logic [15:0]       ok_total_ff, ok_total_in;
   logic [15:0]       fail_total_ff, fail_total_in;
   logic              idle_ff, idle_in;

   logic              advance;
   logic [31:0]       ok_wide, fail_wide;
   sector_type        sector;

   // a beat leaves the request register when the response slot is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   fws_sector_map u_sector_map (
      .offset (offset_ff),
      .sector (sector)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         cmd_ff  <= req_command;
         addr_ff <= req_job_address;
         len_ff  <= req_job_length;
         base_ff <= req_buffer_base;
         busy_ff <= req_flash_busy;
         err_ff  <= req_flash_error;
      end
   end

   // sequencer state, written when a beat moves to the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         win_start_ff <= '1;
         win_end_ff   <= '1;
         offset_ff    <= '0;
         left_ff      <= '0;
         pointer_ff   <= '0;
         ok_cnt_ff    <= '0;
         fail_cnt_ff  <= '0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         win_start_ff <= win_start_in;
         win_end_ff   <= win_end_in;
         offset_ff    <= offset_in;
         left_ff      <= left_in;
         pointer_ff   <= pointer_in;
         ok_cnt_ff    <= ok_cnt_in;
         fail_cnt_ff  <= fail_cnt_in;
      end
   end

   // next phase and per-beat outputs
   always_comb begin
      phase_in     = phase_ff;
      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      offset_in    = offset_ff;
      left_in      = left_ff;
      pointer_in   = pointer_ff;
      ok_cnt_in    = ok_cnt_ff;
      fail_cnt_in  = fail_cnt_ff;
      op_kind_in   = OP_NONE;
      op_addr_in   = '0;
      data_addr_in = '0;
      taken_in     = 1'b0;
      outcome_in   = OUTCOME_NONE;

      unique case (cmd_ff)
         CMD_SUBMIT: begin
            // only an idle sequencer takes a job, and never an empty one
            if (phase_ff == PH_IDLE && len_ff != '0) begin
               offset_in  = addr_ff;
               left_in    = len_ff;
               pointer_in = base_ff;
               phase_in   = PH_START;
               taken_in   = 1'b1;
            end
         end
         CMD_INIT: begin
            ok_cnt_in    = '0;
            fail_cnt_in  = '0;
            win_start_in = '1;
            win_end_in   = '1;
            phase_in     = PH_IDLE;
         end
         CMD_TICK: begin
            unique case (phase_ff)
               PH_START: begin
                  // page already inside the erased window: skip the erase
                  if (offset_ff >= win_start_ff && offset_ff < win_end_ff) begin
                     phase_in = PH_PAGE;
                  end else if (!sector.hit) begin
                     // past the end of the plane
                     phase_in = PH_ERROR;
                  end else begin
                     win_start_in = sector.first;
                     win_end_in   = sector.last;
                     op_kind_in   = OP_ERASE;
                     op_addr_in   = sector.first;
                     phase_in     = err_ff ? PH_ERROR : PH_ERASE_WAIT;
                  end
               end
               PH_ERASE_WAIT: begin
                  if (!busy_ff) begin
                     phase_in = err_ff ? PH_ERROR : PH_PAGE;
                  end
               end
               PH_PAGE: begin
                  op_kind_in   = OP_PROGRAM;
                  op_addr_in   = offset_ff;
                  data_addr_in = pointer_ff;
                  phase_in     = err_ff ? PH_ERROR : PH_PAGE_WAIT;
               end
               PH_PAGE_WAIT: begin
                  if (!busy_ff) begin
                     if (err_ff) begin
                        phase_in = PH_ERROR;
                     end else begin
                        offset_in  = offset_ff + PageStep;
                        pointer_in = pointer_ff + PagePtr;
                        // remaining length saturates at zero on a short last page
                        left_in    = (left_ff >= PageLength) ? left_ff - PageLength : '0;
                        phase_in   = (left_in != '0) ? PH_START : PH_OK;
                     end
                  end
               end
               PH_OK: begin
                  ok_cnt_in  = ok_cnt_ff + 1'b1;
                  outcome_in = OUTCOME_OK;
                  phase_in   = PH_FINISH;
               end
               PH_ERROR: begin
                  fail_cnt_in = fail_cnt_ff + 1'b1;
                  outcome_in  = OUTCOME_FAIL;
                  phase_in    = PH_FINISH;
               end
               PH_FINISH: begin
                  phase_in = PH_IDLE;
               end
               PH_IDLE: begin
                  // tick while idle does nothing
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         default: begin
            // unused command code, state unchanged
            phase_in = phase_ff;
         end
      endcase
   end

   // counters are reported as their low 16 bits, zero extended when narrower
   assign ok_wide       = 32'(ok_cnt_in);
   assign fail_wide     = 32'(fail_cnt_in);
   assign ok_total_in   = ok_wide[15:0];
   assign fail_total_in = fail_wide[15:0];
   assign idle_in       = (phase_in == PH_IDLE);

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         op_kind_ff    <= op_kind_in;
         op_addr_ff    <= op_addr_in;
         data_addr_ff  <= data_addr_in;
         taken_ff      <= taken_in;
         outcome_ff    <= outcome_in;
         ok_total_ff   <= ok_total_in;
         fail_total_ff <= fail_total_in;
         idle_ff       <= idle_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_op_kind      = op_kind_ff;
   assign rsp_op_address   = op_addr_ff;
   assign rsp_data_address = data_addr_ff;
   assign rsp_job_taken    = taken_ff;
   assign rsp_job_outcome  = outcome_ff;
   assign rsp_ok_total     = ok_total_ff;
   assign rsp_fail_total   = fail_total_ff;
   assign rsp_idle         = idle_ff;

endmodule

// ===== rtl/core/fws_checker.sv =====
`timescale 1ns / 1ps
// port checker of the flash write sequencer and its bind
module fws_port_checks
   import fws_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_op_kind,
   input logic [20:0] rsp_op_address,
   input logic [31:0] rsp_data_address,
   input logic        rsp_job_taken,
   input logic [1:0]  rsp_job_outcome,
   input logic [15:0] rsp_ok_total,
   input logic [15:0] rsp_fail_total,
   input logic        rsp_idle
);

   // no response beat right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_op_kind)
         && $stable(rsp_op_address) && $stable(rsp_data_address)
         && $stable(rsp_job_outcome) && $stable(rsp_ok_total)
         && $stable(rsp_fail_total) && $stable(rsp_idle))
      else $error("stalled response beat changed");

   // an issued operation leaves a job running and reports no outcome yet
   a_op_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_op_kind != OP_NONE |->
         !rsp_idle && !rsp_job_taken && rsp_job_outcome == OUTCOME_NONE)
      else $error("operation issued with idle, taken or outcome");

   // addresses are zero unless the matching operation is issued
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_op_kind != OP_PROGRAM |->
         rsp_data_address == '0 && (rsp_op_kind == OP_ERASE || rsp_op_address == '0))
      else $error("address set without matching operation");

   // an outcome beat is followed by the finish step, never idle at once
   a_outcome_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_job_outcome == OUTCOME_OK || rsp_job_outcome == OUTCOME_FAIL) |->
         !rsp_idle && !rsp_job_taken)
      else $error("outcome reported with idle or taken");

endmodule

bind flash_write_sequencer fws_port_checks u_fws_port_checks (.*);

// ===== tb/sv/fws_checker.sv =====
`timescale 1ns / 1ps
// scoreboard that predicts and checks each response beat of the flash write sequencer
module fws_checker
   import fws_pkg::*;
#(
   parameter int PAGE_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [20:0] req_job_address,
   input  logic [15:0] req_job_length,
   input  logic [31:0] req_buffer_base,
   input  logic        req_flash_busy,
   input  logic        req_flash_error,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_op_kind,
   input  logic [20:0] rsp_op_address,
   input  logic [31:0] rsp_data_address,
   input  logic        rsp_job_taken,
   input  logic [1:0]  rsp_job_outcome,
   input  logic [15:0] rsp_ok_total,
   input  logic [15:0] rsp_fail_total,
   input  logic        rsp_idle,

   output int          mismatches,
   output int          outstanding
);

   localparam logic [20:0] PageStep   = 21'(PAGE_BYTES);
   localparam logic [31:0] PagePtr    = 32'(PAGE_BYTES);
   localparam logic [15:0] PageLength = 16'(PAGE_BYTES);

   typedef struct packed {
      logic [1:0]  op_kind;
      logic [20:0] op_address;
      logic [31:0] data_address;
      logic        job_taken;
      logic [1:0]  job_outcome;
      logic [15:0] ok_total;
      logic [15:0] fail_total;
      logic        idle;
   } report_type;

   report_type  pending_reports [$];
   int          fail_tally = 0;
   int          queued = 0;

   // shadow of the sequencer state
   phase_type   seq_phase;
   logic [20:0] win_first;
   logic [20:0] win_last;
   logic [20:0] cur_offset;
   logic [15:0] bytes_left;
   logic [31:0] buf_ptr;
   logic [15:0] ok_count;
   logic [15:0] fail_count;

   assign mismatches  = fail_tally;
   assign outstanding = queued;

   function automatic report_type sequence_step(input logic [1:0] cmd, input logic [20:0] addr,
                                                input logic [15:0] len, input logic [31:0] base,
                                                input logic busy, input logic err);
      report_type  r;
      logic [21:0] plane_addr;
      logic [21:0] sector_lo;
      logic [21:0] sector_hi;
      logic        found;
      r = '0;
      case (cmd)
         CMD_SUBMIT: begin
            if (seq_phase == PH_IDLE && len != 16'd0) begin
               cur_offset  = addr;
               bytes_left  = len;
               buf_ptr     = base;
               seq_phase   = PH_START;
               r.job_taken = 1'b1;
            end
         end
         CMD_INIT: begin
            ok_count   = '0;
            fail_count = '0;
            win_first  = '1;
            win_last   = '1;
            seq_phase  = PH_IDLE;
         end
         CMD_TICK: begin
            case (seq_phase)
               PH_START: begin
                  if (cur_offset >= win_first && cur_offset < win_last) begin
                     seq_phase = PH_PAGE;
                  end else begin
                     plane_addr = {1'b0, cur_offset} + BOOT_BYTES;
                     found      = 1'b0;
                     for (int k = 0; k < SECTOR_COUNT; k++) begin
                        if (plane_addr >= SECTOR_BOUNDS[k] && plane_addr < SECTOR_BOUNDS[k + 1]) begin
                           found     = 1'b1;
                           sector_lo = SECTOR_BOUNDS[k] - BOOT_BYTES;
                           sector_hi = SECTOR_BOUNDS[k + 1] - BOOT_BYTES - 22'd1;
                           win_first = sector_lo[20:0];
                           win_last  = sector_hi[20:0];
                        end
                     end
                     if (!found) begin
                        seq_phase = PH_ERROR;
                     end else begin
                        r.op_kind    = OP_ERASE;
                        r.op_address = win_first;
                        seq_phase    = err ? PH_ERROR : PH_ERASE_WAIT;
                     end
                  end
               end
               PH_ERASE_WAIT: begin
                  if (!busy) seq_phase = err ? PH_ERROR : PH_PAGE;
               end
               PH_PAGE: begin
                  r.op_kind      = OP_PROGRAM;
                  r.op_address   = cur_offset;
                  r.data_address = buf_ptr;
                  seq_phase      = err ? PH_ERROR : PH_PAGE_WAIT;
               end
               PH_PAGE_WAIT: begin
                  if (!busy) begin
                     if (err) begin
                        seq_phase = PH_ERROR;
                     end else begin
                        cur_offset = cur_offset + PageStep;
                        buf_ptr    = buf_ptr + PagePtr;
                        if (bytes_left >= PageLength) bytes_left = bytes_left - PageLength;
                        else bytes_left = '0;
                        seq_phase = (bytes_left != 16'd0) ? PH_START : PH_OK;
                     end
                  end
               end
               PH_OK: begin
                  ok_count      = ok_count + 16'd1;
                  r.job_outcome = OUTCOME_OK;
                  seq_phase     = PH_FINISH;
               end
               PH_ERROR: begin
                  fail_count    = fail_count + 16'd1;
                  r.job_outcome = OUTCOME_FAIL;
                  seq_phase     = PH_FINISH;
               end
               PH_FINISH: begin
                  seq_phase = PH_IDLE;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.ok_total   = ok_count;
      r.fail_total = fail_count;
      r.idle       = (seq_phase == PH_IDLE);
      return r;
   endfunction

   function automatic void compare(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s: expected 0x%0h, actual 0x%0h", $time, field, want, got);
         fail_tally++;
      end
   endfunction

   always @(posedge clock) begin : watch
      report_type want;
      if (reset) begin
         seq_phase  = PH_IDLE;
         win_first  = '1;
         win_last   = '1;
         cur_offset = '0;
         bytes_left = '0;
         buf_ptr    = '0;
         ok_count   = '0;
         fail_count = '0;
         pending_reports.delete();
      end else begin
         // drain before predicting, a response never belongs to the beat taken this edge
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t response beat: expected none, actual op_kind 0x%0h outcome 0x%0h",
                        $time, rsp_op_kind, rsp_job_outcome);
               fail_tally++;
            end else begin
               want = pending_reports.pop_front();
               compare("op_kind", 32'(want.op_kind), 32'(rsp_op_kind));
               compare("op_address", 32'(want.op_address), 32'(rsp_op_address));
               compare("data_address", want.data_address, rsp_data_address);
               compare("job_taken", 32'(want.job_taken), 32'(rsp_job_taken));
               compare("job_outcome", 32'(want.job_outcome), 32'(rsp_job_outcome));
               compare("ok_total", 32'(want.ok_total), 32'(rsp_ok_total));
               compare("fail_total", 32'(want.fail_total), 32'(rsp_fail_total));
               compare("idle", 32'(want.idle), 32'(rsp_idle));
            end
         end
         if (req_valid && req_ready)
            pending_reports.push_back(sequence_step(req_command, req_job_address,
                                                    req_job_length, req_buffer_base,
                                                    req_flash_busy, req_flash_error));
      end
      queued = pending_reports.size();
   end

endmodule

// ===== tb/sv/tb_flash_write_sequencer.sv =====
`timescale 1ns / 1ps
// top of the flash write sequencer regression: clock, reset, stimulus and verdict
module tb_flash_write_sequencer;
   import fws_pkg::*;

   localparam int PAGE_BYTES  = 256;
   localparam int COUNT_WIDTH = 16;
   localparam int ITEM_TARGET = 550;
   // far beyond the slowest honest run
   localparam int CYCLE_LIMIT = 200000;
   // long receiver hold-off, placed while the sender is still busy
   localparam int HOLDOFF_AT  = 400;
   localparam int HOLDOFF_LEN = 160;

   // command code the block must ignore
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // receiver stall patterns
   localparam int RX_STEADY   = 0;
   localparam int RX_COIN     = 1;
   localparam int RX_EVERY4TH = 2;
   localparam int RX_SPARSE   = 3;

   typedef struct {
      logic [1:0]  command;
      logic [20:0] job_address;
      logic [15:0] job_length;
      logic [31:0] buffer_base;
      logic        flash_busy;
      logic        flash_error;
   } request_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [20:0] req_job_address;
   logic [15:0] req_job_length;
   logic [31:0] req_buffer_base;
   logic        req_flash_busy;
   logic        req_flash_error;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_op_kind;
   logic [20:0] rsp_op_address;
   logic [31:0] rsp_data_address;
   logic        rsp_job_taken;
   logic [1:0]  rsp_job_outcome;
   logic [15:0] rsp_ok_total;
   logic [15:0] rsp_fail_total;
   logic        rsp_idle;

   int          mismatches;
   int          outstanding;
   int          cycles;

   request_type request_plan [$];
   logic [20:0] last_job_address = '0;

   flash_write_sequencer #(
      .PAGE_BYTES (PAGE_BYTES),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_job_address (req_job_address),
      .req_job_length  (req_job_length),
      .req_buffer_base (req_buffer_base),
      .req_flash_busy  (req_flash_busy),
      .req_flash_error (req_flash_error),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_op_kind     (rsp_op_kind),
      .rsp_op_address  (rsp_op_address),
      .rsp_data_address(rsp_data_address),
      .rsp_job_taken   (rsp_job_taken),
      .rsp_job_outcome (rsp_job_outcome),
      .rsp_ok_total    (rsp_ok_total),
      .rsp_fail_total  (rsp_fail_total),
      .rsp_idle        (rsp_idle)
   );

   fws_checker #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_job_address (req_job_address),
      .req_job_length  (req_job_length),
      .req_buffer_base (req_buffer_base),
      .req_flash_busy  (req_flash_busy),
      .req_flash_error (req_flash_error),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_op_kind     (rsp_op_kind),
      .rsp_op_address  (rsp_op_address),
      .rsp_data_address(rsp_data_address),
      .rsp_job_taken   (rsp_job_taken),
      .rsp_job_outcome (rsp_job_outcome),
      .rsp_ok_total    (rsp_ok_total),
      .rsp_fail_total  (rsp_fail_total),
      .rsp_idle        (rsp_idle),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // append one request beat to the stimulus list
   function automatic void plan(input logic [1:0] cmd, input logic [20:0] addr,
                                input logic [15:0] len, input logic [31:0] base,
                                input logic busy, input logic err);
      request_type r;
      r.command     = cmd;
      r.job_address = addr;
      r.job_length  = len;
      r.buffer_base = base;
      r.flash_busy  = busy;
      r.flash_error = err;
      request_plan.push_back(r);
   endfunction

   // status tick; the job fields are don't-care here, so they carry noise
   function automatic void plan_tick(input logic busy, input logic err);
      plan(CMD_TICK, 21'($urandom()), 16'($urandom()), $urandom(), busy, err);
   endfunction

   // job offsets that hit sector starts, sector ends, the plane end, the last
   // window again, or just land anywhere
   function automatic logic [20:0] pick_job_address();
      logic [31:0] rnd;
      logic [21:0] spot;
      int          k;
      rnd = $urandom();
      k   = $urandom_range(0, SECTOR_COUNT - 1);
      case ($urandom_range(0, 7))
         0: spot = SECTOR_BOUNDS[k] - BOOT_BYTES;
         1: spot = SECTOR_BOUNDS[k + 1] - BOOT_BYTES
                   - 22'(PAGE_BYTES * $urandom_range(1, 3));
         2: spot = 22'h1F0000 + 22'(PAGE_BYTES * $urandom_range(0, 255));
         3: spot = {1'b0, rnd[20:8], 8'h00};
         4: spot = {1'b0, last_job_address};
         5: spot = {1'b0, last_job_address} + 22'(PAGE_BYTES * $urandom_range(1, 16));
         6: spot = {1'b0, rnd[20:0]};
         default: spot = {4'h0, rnd[17:8], 8'h00};
      endcase
      last_job_address = spot[20:0];
      return spot[20:0];
   endfunction

   // a submit followed by roughly the ticks it needs to run out; busy ticks
   // stretch the waits, a faulty job sees error flags, and now and then a
   // stray submit or init lands in the middle
   function automatic void plan_job(input logic [20:0] addr, input logic [15:0] len,
                                    input logic [31:0] base, input bit faulty);
      int   ticks_needed;
      int   spent;
      logic busy;
      logic err;
      plan(CMD_SUBMIT, addr, len, base, 1'($urandom()), 1'($urandom()));
      ticks_needed = ((int'(len) + PAGE_BYTES - 1) / PAGE_BYTES) * 4 + 3;
      // past the plane the job fails at once
      if (addr >= 21'h1F0000) ticks_needed = 3;
      spent = 0;
      while (ticks_needed > 0) begin
         if (spent == 96 || $urandom_range(0, 149) == 0) begin
            // long job or chance abort: drop it with an init
            plan(CMD_INIT, 21'($urandom()), 16'($urandom()), $urandom(), 1'b0, 1'b0);
            ticks_needed = 0;
         end else if ($urandom_range(0, 39) == 0) begin
            plan(CMD_SUBMIT, pick_job_address(), 16'($urandom_range(1, 65535)), $urandom(),
                 1'b0, 1'b0);
         end else begin
            busy = ($urandom_range(0, 3) == 0);
            err  = faulty && ($urandom_range(0, 11) == 0);
            plan_tick(busy, err);
            if (!busy) ticks_needed--;
            spent++;
         end
      end
   endfunction

   // mostly short jobs, a few up to the full length field
   function automatic logic [15:0] pick_job_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 16'($urandom_range(1, 256));
      if (r < 80) return 16'($urandom_range(257, 1024));
      if (r < 95) return 16'($urandom_range(1025, 4096));
      return 16'($urandom_range(4097, 65535));
   endfunction

   initial begin
      int idx;
      int burst;
      int gap;
      int directed_items;
      int r;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_command     <= CMD_TICK;
      req_job_address <= '0;
      req_job_length  <= '0;
      req_buffer_base <= '0;
      req_flash_busy  <= 1'b0;
      req_flash_error <= 1'b0;

      // directed: init, tick while idle, unknown command, zero length submit
      plan(CMD_INIT, '0, '0, '0, 1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan(CMD_UNUSED, '1, '1, '1, 1'b1, 1'b1);
      plan(CMD_SUBMIT, '1, '0, '1, 1'b1, 1'b1);

      // two-page job at offset zero with a buffer that wraps past the top,
      // a submit while busy, and busy flags in both wait phases
      plan(CMD_SUBMIT, 21'h000000, 16'h0101, 32'hFFFFFF80, 1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan(CMD_SUBMIT, 21'h000100, 16'hFFFF, 32'h12345678, 1'b0, 1'b0);
      plan_tick(1'b1, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b1, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);

      // offset past the plane
      plan(CMD_SUBMIT, 21'h1FFFFF, 16'hFFFF, 32'h00000000, 1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);

      // last byte of the erased window counts as outside, erase then errors
      plan(CMD_SUBMIT, 21'h00FFFF, 16'h0001, 32'h00000000, 1'b0, 1'b0);
      plan_tick(1'b0, 1'b1);
      plan_tick(1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);

      // init drops a job in flight
      plan(CMD_SUBMIT, 21'h040000, 16'h8000, 32'hA5A5A500, 1'b0, 1'b0);
      plan_tick(1'b0, 1'b0);
      plan(CMD_INIT, '0, '0, '0, 1'b0, 1'b0);

      // random: mostly well formed jobs, the rest noise
      directed_items = request_plan.size();
      while (request_plan.size() < directed_items + ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 80)
            plan_job(pick_job_address(), pick_job_length(),
                     ($urandom_range(0, 7) == 0) ? 32'hFFFFFFFF - $urandom_range(0, 1023)
                                                 : $urandom(),
                     $urandom_range(0, 99) < 20);
         else if (r < 90)
            plan(2'($urandom_range(0, 3)), 21'($urandom()), 16'($urandom()), $urandom(),
                 1'($urandom()), 1'($urandom()));
         else if (r < 95)
            plan(CMD_SUBMIT, 21'($urandom()), '0, $urandom(), 1'b0, 1'b0);
         else
            plan(CMD_INIT, 21'($urandom()), 16'($urandom()), $urandom(), 1'b0, 1'b0);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // sender: bursts of back-to-back beats with random gaps between them
      idx = 0;
      while (idx < request_plan.size()) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && idx < request_plan.size()) begin
            req_valid       <= 1'b1;
            req_command     <= request_plan[idx].command;
            req_job_address <= request_plan[idx].job_address;
            req_job_length  <= request_plan[idx].job_length;
            req_buffer_base <= request_plan[idx].buffer_base;
            req_flash_busy  <= request_plan[idx].flash_busy;
            req_flash_error <= request_plan[idx].flash_error;
            do @(posedge clock); while (!req_ready);
            idx++;
            burst--;
         end
         // a zero gap keeps valid high straight into the next burst
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0 && idx < request_plan.size()) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      // let the last beat be counted, then drain, then wait on
      // so a stray extra beat would still show
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: switches between stall patterns at random, and holds off
   // once for a long stretch so the block backs up into its input
   initial begin
      int stall_clock;
      int mode;
      int mode_left;
      stall_clock = 0;
      mode        = RX_STEADY;
      mode_left   = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         stall_clock++;
         if (stall_clock == HOLDOFF_AT) begin
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_LEN) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(RX_STEADY, RX_SPARSE);
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
               RX_STEADY:   rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= ($urandom_range(0, 1) == 1);
               RX_EVERY4TH: rsp_ready <= (stall_clock % 4 == 0);
               default:     rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // watchdog
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/fws_pkg.sv
rtl/core/fws_sector_map.sv
rtl/core/flash_write_sequencer.sv
rtl/core/fws_checker.sv
tb/sv/fws_checker.sv
tb/sv/tb_flash_write_sequencer.sv
